// ===== hw/rtl/hrhp_pkg.sv =====
// Package for the HTTP request header parser: status codes, match strings, payload types.
// Depends on nothing; every other source file uses it.
package hrhp_pkg;

    localparam logic [1:0] ST_MORE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [4:0] CLEN_N  = 5'd14;
    localparam logic [4:0] CTYPE_N = 5'd12;
    localparam logic [4:0] JSON_N  = 5'd16;

    localparam logic [0:13][7:0] NAME_CLEN  = "content-length";
    localparam logic [0:11][7:0] NAME_CTYPE = "content-type";
    localparam logic [0:15][7:0] TEXT_JSON  = "application/json";

    localparam logic [31:0] BODY_DEFAULT = 32'd1048576;
    localparam logic [15:0] HDR_DEFAULT  = 16'd8192;

    localparam logic [0:0] CFG_MAX_BODY = 1'd0;
    localparam logic [0:0] CFG_MAX_HDR  = 1'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [16:0] meth_bytes;
        logic [16:0] target_bytes;
        logic [16:0] header_len;
        logic [31:0] content_bytes;
        logic        is_json;
    } out_item_t;

    typedef struct packed {
        logic [31:0] index;
        logic [31:0] value;
    } cfg_item_t;

    // Lower-case an ASCII letter.
    function automatic logic [7:0] to_lower(input logic [7:0] b);
        to_lower = (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

endpackage

// ===== hw/rtl/hrhp_in_if.sv =====
// Valid/ready channel interfaces for input beats, result beats and config writes.
// Depends on hrhp_pkg.
interface hrhp_in_if;
    logic               valid;
    logic               ready;
    hrhp_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hrhp_out_if;
    logic                valid;
    logic                ready;
    hrhp_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface hrhp_cfg_if;
    logic                valid;
    logic                ready;
    hrhp_pkg::cfg_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/hrhp_fifo.sv =====
// Short queue of input beats between the front and the back of the parser.
// Depends on hrhp_pkg.
module hrhp_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hrhp_pkg::in_item_t push_data,
    output logic               full,
    input  logic               pop,
    output hrhp_pkg::in_item_t pop_data,
    output logic               not_empty
);
    import hrhp_pkg::*;

    in_item_t   mem_reg [2];
    logic [0:0] wptr_reg;
    logic [0:0] rptr_reg;
    logic [1:0] count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign pop_data  = mem_reg[rptr_reg];

    // Pointer and count update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end
endmodule

// ===== hw/rtl/hrhp_back.sv =====
// Back end of the parser: consumes queued beats and runs the byte state machine.
// Depends on hrhp_pkg; result beats leave through an output register.
module hrhp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  hrhp_pkg::in_item_t  item,
    output logic                item_pop,
    input  logic [31:0]         body_limit,
    input  logic [15:0]         hdr_limit,
    output logic                res_valid,
    input  logic                res_ready,
    output hrhp_pkg::out_item_t res
);
    import hrhp_pkg::*;

    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_PATH    = 4'd1,
        PH_REQREST = 4'd2,
        PH_SKIP    = 4'd3,
        PH_NAME    = 4'd4,
        PH_VLEAD   = 4'd5,
        PH_VALUE   = 4'd6,
        PH_LREST   = 4'd7,
        PH_BODY    = 4'd8
    } phase_t;

    logic [23:0] recent_reg, recent_next;
    logic [16:0] seen_reg, seen_next;
    phase_t      phase_reg, phase_next;
    logic [16:0] mcnt_reg, mcnt_next;
    logic [16:0] pcnt_reg, pcnt_next;
    logic [4:0]  npos_reg, npos_next;
    logic [1:0]  nflags_reg, nflags_next;
    logic [4:0]  vpos_reg, vpos_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] body_reg, body_next;
    logic        json_reg, json_next;
    logic        perr_reg, perr_next;
    logic [1:0]  stat_reg, stat_next;
    logic        rv_reg;
    out_item_t   res_reg, res_next;
    logic        step;

    assign step     = item_valid && (!rv_reg || res_ready);
    assign item_pop = step;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    // Next state for one byte.
    always_comb
    begin
        logic [7:0]  b;
        logic [7:0]  c;
        logic        hdr_end;
        logic [35:0] prod;
        logic [1:0]  nf;
        b = item.data_byte;
        c = to_lower(b);
        prod = '0;
        nf = 2'b00;
        hdr_end = 1'b0;
        recent_next = recent_reg;
        seen_next   = seen_reg;
        phase_next  = phase_reg;
        mcnt_next   = mcnt_reg;
        pcnt_next   = pcnt_reg;
        npos_next   = npos_reg;
        nflags_next = nflags_reg;
        vpos_next   = vpos_reg;
        acc_next    = acc_reg;
        body_next   = body_reg;
        json_next   = json_reg;
        perr_next   = perr_reg;
        stat_next   = stat_reg;
        if (item.first_byte)
        begin
            recent_next = '0; seen_next = '0; phase_next = PH_METHOD;
            mcnt_next = '0; pcnt_next = '0; npos_next = '0; nflags_next = 2'b11;
            vpos_next = '0; acc_next = '0; body_next = '0; json_next = 1'b0;
            perr_next = 1'b0; stat_next = ST_MORE;
        end
        if (stat_next == ST_MORE)
        begin
            if (phase_next != PH_BODY)
            begin
                seen_next   = seen_next + 17'd1;
                hdr_end     = (recent_next == 24'h0D0A0D) && (b == 8'h0A);
                recent_next = {recent_next[15:0], b};
                unique case (phase_next) inside
                    PH_METHOD:
                    begin
                        if (b == 8'h0D)
                        begin
                            perr_next = 1'b1; phase_next = PH_SKIP;
                        end
                        else if (b == 8'h20)
                        begin
                            if (mcnt_next == '0) perr_next = 1'b1;
                            phase_next = PH_PATH;
                        end
                        else mcnt_next = mcnt_next + 17'd1;
                    end
                    PH_PATH:
                    begin
                        if (b == 8'h0D)
                        begin
                            perr_next = 1'b1; phase_next = PH_SKIP;
                        end
                        else if (b == 8'h20)
                        begin
                            if (pcnt_next == '0) perr_next = 1'b1;
                            phase_next = PH_REQREST;
                        end
                        else pcnt_next = pcnt_next + 17'd1;
                    end
                    PH_SKIP:
                    begin
                        phase_next = PH_NAME; npos_next = '0; nflags_next = 2'b11;
                    end
                    PH_NAME:
                    begin
                        if (b == 8'h0D) phase_next = PH_SKIP;
                        else if (b == 8'h3A)
                        begin
                            if (nflags_next[0] && npos_next == CLEN_N)
                            begin
                                nflags_next = 2'b01; acc_next = '0; vpos_next = '0;
                                phase_next = PH_VLEAD;
                            end
                            else if (nflags_next[1] && npos_next == CTYPE_N)
                            begin
                                nflags_next = 2'b10; vpos_next = '0; phase_next = PH_VLEAD;
                            end
                            else phase_next = PH_LREST;
                        end
                        else if (nflags_next != 2'b00)
                        begin
                            nf = nflags_next;
                            if (npos_next >= CLEN_N || c != NAME_CLEN[npos_next[3:0]])
                                nf[0] = 1'b0;
                            if (npos_next >= CTYPE_N || c != NAME_CTYPE[npos_next[3:0]])
                                nf[1] = 1'b0;
                            nflags_next = nf;
                            if (nf != 2'b00) npos_next = npos_next + 5'd1;
                        end
                    end
                    PH_VLEAD, PH_VALUE:
                    begin
                        if (phase_next == PH_VLEAD && (b == 8'h20 || b == 8'h09))
                        begin
                            phase_next = PH_VLEAD;
                        end
                        else if (b == 8'h0D) phase_next = PH_SKIP;
                        else if (b == 8'h0A) phase_next = PH_LREST;
                        else
                        begin
                            phase_next = PH_VALUE;
                            if (nflags_next == 2'b01)
                            begin
                                if (b >= 8'h30 && b <= 8'h39)
                                begin
                                    prod = {4'd0, acc_next} * 36'd10 + {28'd0, b - 8'h30};
                                    if (prod > {4'd0, body_limit})
                                    begin
                                        perr_next = 1'b1; phase_next = PH_LREST;
                                    end
                                    acc_next = (prod[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                     : prod[31:0];
                                end
                                else
                                begin
                                    acc_next = '0; phase_next = PH_LREST;
                                end
                            end
                            else if (vpos_next < JSON_N && c == TEXT_JSON[vpos_next[3:0]])
                            begin
                                vpos_next = vpos_next + 5'd1;
                                if (vpos_next == JSON_N)
                                begin
                                    json_next = 1'b1; phase_next = PH_LREST;
                                end
                            end
                            else phase_next = PH_LREST;
                        end
                    end
                    default:
                    begin
                        if (b == 8'h0D) phase_next = PH_SKIP;
                    end
                endcase
                if (hdr_end)
                begin
                    phase_next = PH_BODY;
                    if (perr_next || acc_next > body_limit) stat_next = ST_ERROR;
                    else if (acc_next == '0) stat_next = ST_DONE;
                end
                else if (seen_next > {1'b0, hdr_limit})
                begin
                    stat_next = ST_ERROR;
                end
            end
            else
            begin
                if (body_next != 32'hFFFF_FFFF) body_next = body_next + 32'd1;
                if (body_next >= acc_next) stat_next = ST_DONE;
            end
        end
        res_next.status        = stat_next;
        res_next.meth_bytes    = mcnt_next;
        res_next.target_bytes  = pcnt_next;
        res_next.header_len    = seen_next;
        res_next.content_bytes = (stat_next == ST_DONE) ? acc_next : '0;
        res_next.is_json       = json_next;
    end

    // Parser state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0; seen_reg <= '0; phase_reg <= PH_METHOD;
            mcnt_reg <= '0; pcnt_reg <= '0; npos_reg <= '0; nflags_reg <= 2'b11;
            vpos_reg <= '0; acc_reg <= '0; body_reg <= '0; json_reg <= 1'b0;
            perr_reg <= 1'b0; stat_reg <= ST_MORE; rv_reg <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            if (step)
            begin
                recent_reg <= recent_next; seen_reg <= seen_next; phase_reg <= phase_next;
                mcnt_reg <= mcnt_next; pcnt_reg <= pcnt_next; npos_reg <= npos_next;
                nflags_reg <= nflags_next; vpos_reg <= vpos_next; acc_reg <= acc_next;
                body_reg <= body_next; json_reg <= json_next; perr_reg <= perr_next;
                stat_reg <= stat_next;
                rv_reg <= 1'b1;
                res_reg <= res_next;
            end
            else if (res_ready)
            begin
                rv_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== hw/rtl/http_request_header_parser_core.sv =====
// HTTP request header parser: one byte in, one status beat out per byte.
// An input beat is written into the queue, then parsed into the result register.
// Throughput is one byte per cycle while the result receiver keeps up, set by the byte state machine.
// Reset clears all parse state and loads the limits 1048576 and 8192.
// Depends on hrhp_pkg, the channel interfaces, hrhp_fifo and hrhp_back.
module http_request_header_parser_core (
    input logic clk,
    input logic rst_n,
    hrhp_in_if.sink    in_ch,
    hrhp_out_if.source out_ch,
    hrhp_cfg_if.sink   cfg
);
    import hrhp_pkg::*;

    logic [31:0] body_limit_reg;
    logic [15:0] hdr_limit_reg;
    logic        fifo_full;
    logic        fifo_ne;
    logic        fifo_pop;
    in_item_t    fifo_data;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = !fifo_full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_limit_reg <= BODY_DEFAULT;
            hdr_limit_reg  <= HDR_DEFAULT;
        end
        else if (cfg.valid)
        begin
            if (cfg.data.index == {31'd0, CFG_MAX_BODY}) body_limit_reg <= cfg.data.value;
            else if (cfg.data.index == {31'd0, CFG_MAX_HDR})
                hdr_limit_reg <= cfg.data.value[15:0];
        end
    end

    // Front: input queue.
    hrhp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_ch.valid && !fifo_full),
        .push_data (in_ch.data),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .pop_data  (fifo_data),
        .not_empty (fifo_ne)
    );

    // Back: byte parser.
    hrhp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (fifo_ne),
        .item       (fifo_data),
        .item_pop   (fifo_pop),
        .body_limit (body_limit_reg),
        .hdr_limit  (hdr_limit_reg),
        .res_valid  (out_ch.valid),
        .res_ready  (out_ch.ready),
        .res        (out_ch.data)
    );
endmodule

// ===== bench/tb_pkg_dummy.sv =====
`timescale 1ns / 100ps
// Shared stimulus helpers for the parser bench: builds request byte streams.
// Depends on hrhp_pkg only.
package hrhp_tb_pkg;
    import hrhp_pkg::*;

    // Append a string as request bytes; the first byte of a request carries the flag.
    function automatic void push_text(ref in_item_t q[$], input string s, input bit start);
        in_item_t it;
        for (int i = 0; i < s.len(); i++)
        begin
            it.data_byte  = s[i];
            it.first_byte = start && (i == 0);
            q.push_back(it);
        end
    endfunction
endpackage

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for http_request_header_parser_core: byte streams of whole and
// broken requests go in, every status beat is checked against a built-in parser model.
// Depends on hrhp_pkg, hrhp_tb_pkg, the channel interfaces and the core RTL.
module tb;
    import hrhp_pkg::*;
    import hrhp_tb_pkg::*;

    typedef enum logic [3:0] {
        PH_METHOD  = 4'd0,
        PH_PATH    = 4'd1,
        PH_REQREST = 4'd2,
        PH_SKIP    = 4'd3,
        PH_NAME    = 4'd4,
        PH_VLEAD   = 4'd5,
        PH_VALUE   = 4'd6,
        PH_LREST   = 4'd7,
        PH_BODY    = 4'd8
    } phase_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;

    logic clk;
    logic rst_n;

    hrhp_in_if  in_ch ();
    hrhp_out_if out_ch ();
    hrhp_cfg_if cfg ();

    http_request_header_parser_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Clock, 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Limits and parse state of the model.
    logic [31:0] lim_body;
    logic [15:0] lim_hdr;
    logic [23:0] last3;
    logic [16:0] nbytes;
    phase_t      ph;
    logic [16:0] meth_n;
    logic [16:0] path_n;
    logic [4:0]  npos;
    logic [1:0]  nflags;
    logic [4:0]  vpos;
    logic [31:0] clen;
    logic [31:0] body_n;
    logic        json;
    logic        perr;
    logic [1:0]  stat;

    in_item_t  byte_q[$];
    out_item_t status_q[$];
    cfg_item_t reg_q[$];

    int  mismatches;
    int  beats_checked;
    int  requests;
    int  cycles;
    bit  idle_free;
    bit  hold_req;
    int  hold_left;
    bit  stim_done;

    function automatic logic [7:0] lc(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function automatic void clear_parse();
        last3 = '0; nbytes = '0; ph = PH_METHOD; meth_n = '0; path_n = '0;
        npos = '0; nflags = 2'b11; vpos = '0; clen = '0; body_n = '0;
        json = 1'b0; perr = 1'b0; stat = ST_MORE;
    endfunction

    // Header value byte: content-length digits or content-type text.
    function automatic void value_step(input logic [7:0] b);
        logic [63:0] acc;
        if (b == 8'h0D)
        begin
            ph = PH_SKIP;
        end
        else if (b == 8'h0A)
        begin
            ph = PH_LREST;
        end
        else if (nflags == 2'b01)
        begin
            if (b >= "0" && b <= "9")
            begin
                acc = 64'(clen) * 10 + 64'(b - "0");
                if (acc > 64'(lim_body))
                begin
                    perr = 1'b1;
                    ph = PH_LREST;
                end
                clen = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
            end
            else
            begin
                clen = '0;
                ph = PH_LREST;
            end
        end
        else if (vpos < JSON_N && lc(b) == TEXT_JSON[vpos])
        begin
            vpos++;
            if (vpos == JSON_N)
            begin
                json = 1'b1;
                ph = PH_LREST;
            end
        end
        else
        begin
            ph = PH_LREST;
        end
    endfunction

    // Header name byte: track both candidate names until the colon.
    function automatic void name_step(input logic [7:0] b);
        logic [7:0] c;
        if (b == 8'h0D)
        begin
            ph = PH_SKIP;
        end
        else if (b == ":")
        begin
            if (nflags[0] && npos == CLEN_N)
            begin
                nflags = 2'b01; clen = '0; vpos = '0; ph = PH_VLEAD;
            end
            else if (nflags[1] && npos == CTYPE_N)
            begin
                nflags = 2'b10; vpos = '0; ph = PH_VLEAD;
            end
            else
            begin
                ph = PH_LREST;
            end
        end
        else if (nflags != 2'b00)
        begin
            c = lc(b);
            if (npos >= CLEN_N || c != NAME_CLEN[npos])
                nflags[0] = 1'b0;
            if (npos >= CTYPE_N || c != NAME_CTYPE[npos])
                nflags[1] = 1'b0;
            if (nflags != 2'b00)
                npos++;
        end
    endfunction

    function automatic void phase_step(input logic [7:0] b);
        case (ph)
            PH_METHOD:
            begin
                if (b == 8'h0D)
                begin
                    perr = 1'b1; ph = PH_SKIP;
                end
                else if (b == " ")
                begin
                    if (meth_n == 0) perr = 1'b1;
                    ph = PH_PATH;
                end
                else meth_n++;
            end
            PH_PATH:
            begin
                if (b == 8'h0D)
                begin
                    perr = 1'b1; ph = PH_SKIP;
                end
                else if (b == " ")
                begin
                    if (path_n == 0) perr = 1'b1;
                    ph = PH_REQREST;
                end
                else path_n++;
            end
            PH_SKIP:
            begin
                ph = PH_NAME; npos = '0; nflags = 2'b11;
            end
            PH_NAME:  name_step(b);
            PH_VLEAD:
            begin
                if (b != " " && b != 8'h09)
                begin
                    ph = PH_VALUE;
                    value_step(b);
                end
            end
            PH_VALUE: value_step(b);
            default:
            begin
                if (b == 8'h0D) ph = PH_SKIP;
            end
        endcase
    endfunction

    // Advance the model by one byte and return the status beat it gives.
    function automatic out_item_t parse_byte(input in_item_t it);
        out_item_t r;
        logic      term;
        if (it.first_byte)
            clear_parse();
        if (stat == ST_MORE)
        begin
            if (ph != PH_BODY)
            begin
                nbytes++;
                term = (last3 == 24'h0D0A0D) && (it.data_byte == 8'h0A);
                last3 = {last3[15:0], it.data_byte};
                phase_step(it.data_byte);
                if (term)
                begin
                    ph = PH_BODY;
                    if (perr || clen > lim_body) stat = ST_ERROR;
                    else if (clen == 0) stat = ST_DONE;
                end
                else if (32'(nbytes) > 32'(lim_hdr))
                begin
                    stat = ST_ERROR;
                end
            end
            else
            begin
                if (body_n != 32'hFFFF_FFFF) body_n++;
                if (body_n >= clen) stat = ST_DONE;
            end
        end
        r.status        = stat;
        r.meth_bytes    = meth_n;
        r.target_bytes  = path_n;
        r.header_len    = nbytes;
        r.content_bytes = (stat == ST_DONE) ? clen : '0;
        r.is_json       = json;
        return r;
    endfunction

    // Input driver: offers bytes from the pending queue, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                status_q.push_back(parse_byte(in_ch.data));
                void'(byte_q.pop_front());
            end
            if ((!in_ch.valid || in_ch.ready))
            begin
                if (byte_q.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
                    (idle_free || $urandom_range(99) >= 29))
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= byte_q[0];
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Config driver: writes come only from the stimulus while the block is idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.valid <= 1'b0;
            cfg.data  <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.data.index == 32'(CFG_MAX_BODY)) lim_body = cfg.data.value;
                else if (cfg.data.index == 32'(CFG_MAX_HDR)) lim_hdr = cfg.data.value[15:0];
                void'(reg_q.pop_front());
            end
            if (!cfg.valid || cfg.ready)
            begin
                if (reg_q.size() > 0 && !(cfg.valid && cfg.ready && reg_q.size() == 0))
                begin
                    cfg.valid <= 1'b1;
                    cfg.data  <= reg_q[0];
                end
                else
                begin
                    cfg.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here while the sender keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_req && hold_left == 0)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: checks each status beat against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            cycles       <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (out_ch.valid && out_ch.ready)
            begin
                beats_checked++;
                if (status_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected beat %p", out_ch.data);
                end
                else
                begin
                    want = status_q.pop_front();
                    if (out_ch.data !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: beat %0d expected %p got %p",
                                     beats_checked, want, out_ch.data);
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && (idle_free || $urandom_range(99) >= 29);
        end
    end

    // Random bytes weighted toward the parser's delimiters.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(9))
            0: return 8'h0D;
            1: return 8'h0A;
            2: return " ";
            3: return ":";
            4: return 8'("0" + $urandom_range(9));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic string rand_case(input string s);
        string t = s;
        for (int i = 0; i < t.len(); i++)
            if ($urandom_range(1) && t[i] >= "a" && t[i] <= "z")
                t[i] = t[i] - 8'd32;
        return t;
    endfunction

    // One well-formed request with random content, sometimes broken.
    function automatic void add_request();
        string s;
        int    blen;
        s = $sformatf("%s /p%0d HTTP/1.1\r\n", ($urandom_range(1) ? "GET" : "POST"),
                      $urandom_range(999));
        blen = $urandom_range(6);
        if ($urandom_range(3) != 0)
            s = {s, rand_case("content-length"), ":", ($urandom_range(1) ? " \t" : ""),
                 $sformatf("%0d\r\n", blen)};
        if ($urandom_range(1))
            s = {s, rand_case("Content-Type"), ": ",
                 ($urandom_range(2) ? rand_case("application/json") : "text/plain"), "\r\n"};
        if ($urandom_range(2) == 0)
            s = {s, "X-Other: 1\r\n"};
        if ($urandom_range(9) == 0)
            s[$urandom_range(s.len() - 1)] = noise_byte();
        s = {s, "\r\n"};
        for (int i = 0; i < blen + $urandom_range(2); i++)
            s = {s, string'(noise_byte())};
        push_text(byte_q, s, 1'b1);
        requests++;
    endfunction

    task automatic wait_idle();
        while (byte_q.size() > 0 || status_q.size() > 0 || reg_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limits(input logic [31:0] body, input logic [15:0] hdr);
        cfg_item_t c;
        wait_idle();
        c.index = 32'(CFG_MAX_BODY); c.value = body; reg_q.push_back(c);
        c.index = 32'(CFG_MAX_HDR);  c.value = 32'(hdr); reg_q.push_back(c);
        wait_idle();
    endtask

    // Stimulus.
    initial
    begin
        in_item_t it;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg.valid    = 1'b0;
        cfg.data     = '0;
        out_ch.ready = 1'b0;
        lim_body = BODY_DEFAULT;
        lim_hdr  = HDR_DEFAULT;
        clear_parse();
        mismatches = 0; beats_checked = 0; requests = 0;
        idle_free = 1'b0; hold_req = 1'b0; stim_done = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: good json POST, bad request lines, oversized length, extreme bytes.
        push_text(byte_q, "POST /a HTTP/1.1\r\nCONTENT-TYPE:  APPLICATION/JSON\r\n", 1);
        push_text(byte_q, "Content-Length: 3\r\n\r\nabc", 0);
        push_text(byte_q, " / x\r\n\r\n", 1);
        push_text(byte_q, "GET\r\n\r\n", 1);
        push_text(byte_q, "GET /\r\ncontent-length: 9x\r\n\r\n", 1);
        push_text(byte_q, "A  \r\ncontent-length: 99999999999\r\n\r\n", 1);
        it.data_byte = 8'hFF; it.first_byte = 1'b1; byte_q.push_back(it);
        it.data_byte = 8'h00; it.first_byte = 1'b0; byte_q.push_back(it);
        set_limits(32'd0, 16'd4);
        push_text(byte_q, "GET / H\r\n\r\n", 1);
        set_limits(32'hFFFF_FFFF, 16'hFFFF);
        push_text(byte_q, "G / H\r\ncontent-length:4294967295\r\n\r\nzz", 1);
        set_limits(32'd5, 16'd40);

        // Random requests across several limit settings; one long receiver hold-off.
        for (int k = 0; k < 4; k++)
        begin
            idle_free = (k == 2);
            add_request();
            for (int j = 0; j < 3; j++)
                for (int i = 0; i < 2; i++)
                begin
                    it.data_byte = 8'($urandom_range(255));
                    it.first_byte = ($urandom_range(7) == 0);
                    byte_q.push_back(it);
                end
            if (k == 1)
            begin
                hold_req = 1'b1;
                wait (hold_left > 0);
                hold_req = 1'b0;
            end
            set_limits($urandom_range(3) == 0 ? 32'd2 : 32'd1000, 16'(40 + 30 * k));
        end
        wait_idle();
        stim_done = 1'b1;
    end

    // End of run or timeout.
    initial
    begin
        wait (stim_done || cycles >= CYCLE_LIMIT);
        if (!stim_done)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("http_request_header_parser_core regression: fail");
            $finish;
        end
        else
        begin
            $display("Checked %0d status beats over %0d random requests plus directed cases.",
                     beats_checked, requests);
            if (mismatches == 0 && status_q.size() == 0)
                $display("http_request_header_parser_core regression: pass");
            else
                $display("http_request_header_parser_core regression: fail");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/hrhp_pkg.sv
hw/rtl/hrhp_in_if.sv
hw/rtl/hrhp_fifo.sv
hw/rtl/hrhp_back.sv
hw/rtl/http_request_header_parser_core.sv
bench/tb_pkg_dummy.sv
bench/tb.sv
